// ===== rtl/tgcw_pkg.sv =====
package tgcw_pkg;

    // Grid limits
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;

    // Port widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    // Reset values of the configuration registers
    localparam logic [8:0] COLUMNS_RST = 9'd80;
    localparam logic [7:0] ROWS_RST    = 8'd24;
    localparam logic [6:0] TOP_RST     = 7'd0;
    localparam logic [6:0] BOTTOM_RST  = 7'd23;
    localparam logic       WRAP_RST    = 1'b1;

    localparam logic [20:0] PAD_GLYPH = 21'h20;

    typedef enum logic [2:0] {
        REG_COLUMNS   = 3'd0,
        REG_ROWS      = 3'd1,
        REG_TOP       = 3'd2,
        REG_BOTTOM    = 3'd3,
        REG_AUTO_WRAP = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_GLYPH      = 3'd0,
        MODE_NEWLINE    = 3'd1,
        MODE_ERASE_LINE = 3'd2,
        MODE_ERASE_DISP = 3'd3,
        MODE_SET_CUR    = 3'd4,
        MODE_RESET_CUR  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_SCROLL    = 3'd1,
        OP_CLR_SPAN  = 3'd2,
        OP_CLR_ALL   = 3'd3,
        OP_CLR_ROWS  = 3'd4,
        OP_CURSOR    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ERASE_TO_END   = 2'd0,
        ERASE_TO_START = 2'd1,
        ERASE_ALL      = 2'd2,
        ERASE_OTHER    = 2'd3
    } erase_t;

    // Clamped geometry seen by the step logic
    typedef struct packed {
        logic [7:0] cmax;       // last usable column
        logic [6:0] rmax;       // last usable row
        logic [6:0] top;
        logic [6:0] bottom;
        logic       auto_wrap;
    } geom_t;

    // One input item
    typedef struct packed {
        logic [2:0]  mode;
        logic [20:0] glyph;
        logic        two_cell;
        logic [15:0] attribute;
        logic        return_to_start;
        logic [1:0]  erase_kind;
        logic [7:0]  target_col;
        logic [6:0]  target_row;
    } in_item_t;

    // One grid operation
    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  row_first;
        logic [6:0]  row_last;
        logic [7:0]  col_first;
        logic [7:0]  col_last;
        logic [20:0] glyph;
        logic [15:0] attribute;
        logic        wide;
    } gop_t;

    // Everything one item produces
    typedef struct packed {
        gop_t [3:0]  ops;
        logic [1:0]  last_idx;
        logic [7:0]  cur_col;
        logic [6:0]  cur_row;
        logic        wrap_pending;
    } step_t;

    typedef struct packed {
        logic [7:0] col;
        logic [6:0] row;
        logic       wrap_pending;
        logic       scroll;
    } nl_t;

    function automatic gop_t mk_op(input op_t op, input logic [6:0] rf, input logic [6:0] rl,
                                   input logic [7:0] cf, input logic [7:0] cl,
                                   input logic [20:0] g, input logic [15:0] a,
                                   input logic w);
        gop_t o;
        o.op        = op;
        o.row_first = rf;
        o.row_last  = rl;
        o.col_first = cf;
        o.col_last  = cl;
        o.glyph     = g;
        o.attribute = a;
        o.wide      = w;
        return o;
    endfunction

    // Line feed with optional carriage return; scroll flag set when the
    // region has to move up
    function automatic nl_t newline_step(input logic cr, input logic [7:0] c,
                                         input logic [6:0] r, input geom_t g);
        nl_t res;
        res.col          = cr ? 8'd0 : c;
        res.row          = r;
        res.wrap_pending = 1'b0;
        res.scroll       = 1'b0;
        if (r == g.bottom) begin
            res.scroll = (g.top <= g.bottom);
        end else if (r < g.rmax) begin
            res.row = r + 7'd1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/text_grid_cursor_wrap_engine_unit.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser mode; tdata glyph..target_row
// m_        out  m_tvalid/m_tready  tuser op; tdata row_first..wrap_pending_now; tlast
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// An item produces 1 to 4 results. While m_ does not stall, the result buffer
// sends one grid operation per cycle and one-result items flow at one per cycle.
// The first result is offered once the item has passed the input register and been
// loaded into the result buffer. Reset (aresetn low, synchronous) clears the cursor,
// the wrap flag and the valid flags and loads the register defaults. A stall on m_
// holds the buffered results and, once the input register is full, drops s_tready.
module text_grid_cursor_wrap_engine_unit #(
    parameter int MAX_COLS = tgcw_pkg::MAX_COLS,
    parameter int MAX_ROWS = tgcw_pkg::MAX_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // glyph[20:0], two_cell[21], attribute[37:22], return_to_start[38],
    // erase_kind[40:39], target_col[48:41], target_row[55:49]
    input  logic [tgcw_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // row_first[6:0], row_last[13:7], col_first[21:14], col_last[29:22],
    // cell_glyph[50:30], cell_attribute[66:51], cell_wide[67],
    // cursor_col_now[75:68], cursor_row_now[82:76], wrap_pending_now[83]
    output logic [tgcw_pkg::M_TDATA_W-1:0]  m_tdata,
    // op[2:0]
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [tgcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgcw_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import tgcw_pkg::*;

    geom_t      geom;
    in_item_t   item_reg;
    logic       in_valid_reg;
    logic       load;
    step_t      res;
    logic [7:0] col_reg;
    logic [6:0] row_reg;
    logic       wrap_reg;

    tgcw_config #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom)
    );

    // Input register
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode            <= s_tuser;
            item_reg.glyph           <= s_tdata[20:0];
            item_reg.two_cell        <= s_tdata[21];
            item_reg.attribute       <= s_tdata[37:22];
            item_reg.return_to_start <= s_tdata[38];
            item_reg.erase_kind      <= s_tdata[40:39];
            item_reg.target_col      <= s_tdata[48:41];
            item_reg.target_row      <= s_tdata[55:49];
        end
    end

    tgcw_step u_step (
        .item     (item_reg),
        .geom     (geom),
        .cur_col  (col_reg),
        .cur_row  (row_reg),
        .cur_wrap (wrap_reg),
        .res      (res)
    );

    // Cursor state advances when an item's results enter the buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= 8'd0;
            row_reg  <= 7'd0;
            wrap_reg <= 1'b0;
        end else if (load) begin
            col_reg  <= res.cur_col;
            row_reg  <= res.cur_row;
            wrap_reg <= res.wrap_pending;
        end
    end

    tgcw_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .res      (res),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/tgcw_config.sv =====
module tgcw_config #(
    parameter int MAX_COLS = tgcw_pkg::MAX_COLS,
    parameter int MAX_ROWS = tgcw_pkg::MAX_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tgcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgcw_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    output tgcw_pkg::geom_t                 geom
);
    import tgcw_pkg::*;

    // grid never exceeds 256 columns by 128 rows, whatever the limits say
    localparam logic [8:0] COLS_CAP = 9'((MAX_COLS < 256) ? MAX_COLS : 256);
    localparam logic [7:0] ROWS_CAP = 8'((MAX_ROWS < 128) ? MAX_ROWS : 128);

    logic [8:0] columns_reg;
    logic [7:0] rows_reg;
    logic [6:0] top_reg;
    logic [6:0] bottom_reg;
    logic       wrap_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLUMNS_RST;
            rows_reg    <= ROWS_RST;
            top_reg     <= TOP_RST;
            bottom_reg  <= BOTTOM_RST;
            wrap_reg    <= WRAP_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_COLUMNS:   columns_reg <= cfg_wdata;
                REG_ROWS:      rows_reg    <= cfg_wdata[7:0];
                REG_TOP:       top_reg     <= cfg_wdata[6:0];
                REG_BOTTOM:    bottom_reg  <= cfg_wdata[6:0];
                REG_AUTO_WRAP: wrap_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp grid size to 1..max and expose last column / last row
    logic [8:0] cols_m1;
    logic [7:0] rows_m1;

    always_comb begin
        cols_m1 = columns_reg - 9'd1;
        rows_m1 = rows_reg - 8'd1;
        if (columns_reg == 9'd0) begin
            geom.cmax = 8'd0;
        end else if (columns_reg > COLS_CAP) begin
            geom.cmax = 8'(COLS_CAP - 9'd1);
        end else begin
            geom.cmax = cols_m1[7:0];
        end
        if (rows_reg == 8'd0) begin
            geom.rmax = 7'd0;
        end else if (rows_reg > ROWS_CAP) begin
            geom.rmax = 7'(ROWS_CAP - 8'd1);
        end else begin
            geom.rmax = rows_m1[6:0];
        end
        geom.top       = top_reg;
        geom.bottom    = bottom_reg;
        geom.auto_wrap = wrap_reg;
    end

endmodule

// ===== rtl/tgcw_step.sv =====
module tgcw_step (
    input  tgcw_pkg::in_item_t item,
    input  tgcw_pkg::geom_t    geom,
    input  logic [7:0]         cur_col,
    input  logic [6:0]         cur_row,
    input  logic               cur_wrap,
    output tgcw_pkg::step_t    res
);
    import tgcw_pkg::*;

    logic [7:0] c;
    logic [6:0] r;
    logic       wp;
    logic [2:0] n;
    logic       wide_now;
    logic [8:0] nc;
    nl_t        nl;
    gop_t [3:0] ops;
    gop_t       zero_op;

    always_comb begin
        zero_op  = mk_op(OP_WRITE, 7'd0, 7'd0, 8'd0, 8'd0, 21'd0, 16'd0, 1'b0);
        ops      = {4{zero_op}};
        n        = 3'd0;
        // cursor is pulled into the current grid first
        c        = (cur_col > geom.cmax) ? geom.cmax : cur_col;
        r        = (cur_row > geom.rmax) ? geom.rmax : cur_row;
        wp       = cur_wrap;
        wide_now = item.two_cell;
        nc       = 9'd0;
        nl       = newline_step(1'b1, c, r, geom);

        unique case (item.mode)
            MODE_GLYPH: begin
                // deferred wrap from the previous glyph
                if (wp && geom.auto_wrap) begin
                    nl = newline_step(1'b1, c, r, geom);
                    c  = nl.col;
                    r  = nl.row;
                    wp = nl.wrap_pending;
                    if (nl.scroll) begin
                        ops[n[1:0]] = mk_op(OP_SCROLL, geom.top, geom.bottom, 8'd0,
                                            geom.cmax, 21'd0, 16'd0, 1'b0);
                        n = n + 3'd1;
                    end
                end
                // wide glyph at the right margin: pad and wrap, or narrow it
                if (wide_now && (c >= geom.cmax)) begin
                    if (geom.auto_wrap) begin
                        ops[n[1:0]] = mk_op(OP_WRITE, r, 7'd0, c, 8'd0, PAD_GLYPH,
                                            item.attribute, 1'b0);
                        n  = n + 3'd1;
                        nl = newline_step(1'b1, c, r, geom);
                        c  = nl.col;
                        r  = nl.row;
                        wp = nl.wrap_pending;
                        if (nl.scroll) begin
                            ops[n[1:0]] = mk_op(OP_SCROLL, geom.top, geom.bottom, 8'd0,
                                                geom.cmax, 21'd0, 16'd0, 1'b0);
                            n = n + 3'd1;
                        end
                    end else begin
                        wide_now = 1'b0;
                    end
                end
                ops[n[1:0]] = mk_op(OP_WRITE, r, 7'd0, c, 8'd0, item.glyph,
                                    item.attribute, wide_now);
                n  = n + 3'd1;
                nc = {1'b0, c} + (wide_now ? 9'd2 : 9'd1);
                if (nc > {1'b0, geom.cmax}) begin
                    wp = 1'b1;
                    c  = geom.cmax;
                end else begin
                    c  = nc[7:0];
                end
            end
            MODE_NEWLINE: begin
                nl = newline_step(item.return_to_start, c, r, geom);
                c  = nl.col;
                r  = nl.row;
                wp = nl.wrap_pending;
                if (nl.scroll) begin
                    ops[n[1:0]] = mk_op(OP_SCROLL, geom.top, geom.bottom, 8'd0,
                                        geom.cmax, 21'd0, 16'd0, 1'b0);
                    n = n + 3'd1;
                end
            end
            MODE_ERASE_LINE: begin
                ops[n[1:0]] = mk_op(OP_CLR_SPAN, r, r,
                                    (item.erase_kind == ERASE_TO_END) ? c : 8'd0,
                                    (item.erase_kind == ERASE_TO_START) ? c : geom.cmax,
                                    21'd0, item.attribute, 1'b0);
                n = n + 3'd1;
            end
            MODE_ERASE_DISP: begin
                unique case (erase_t'(item.erase_kind))
                    ERASE_ALL: begin
                        ops[n[1:0]] = mk_op(OP_CLR_ALL, 7'd0, 7'd0, 8'd0, 8'd0,
                                            21'd0, 16'd0, 1'b0);
                        n = n + 3'd1;
                    end
                    ERASE_TO_END: begin
                        ops[n[1:0]] = mk_op(OP_CLR_SPAN, r, r, c, geom.cmax,
                                            21'd0, item.attribute, 1'b0);
                        n = n + 3'd1;
                        if (r < geom.rmax) begin
                            ops[n[1:0]] = mk_op(OP_CLR_ROWS, r + 7'd1, geom.rmax, 8'd0,
                                                geom.cmax, 21'd0, item.attribute, 1'b0);
                            n = n + 3'd1;
                        end
                    end
                    ERASE_TO_START: begin
                        ops[n[1:0]] = mk_op(OP_CLR_SPAN, r, r, 8'd0, c,
                                            21'd0, item.attribute, 1'b0);
                        n = n + 3'd1;
                        if (r != 7'd0) begin
                            ops[n[1:0]] = mk_op(OP_CLR_ROWS, 7'd0, r - 7'd1, 8'd0,
                                                geom.cmax, 21'd0, item.attribute, 1'b0);
                            n = n + 3'd1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_SET_CUR: begin
                c  = (item.target_col > geom.cmax) ? geom.cmax : item.target_col;
                r  = (item.target_row > geom.rmax) ? geom.rmax : item.target_row;
                wp = 1'b0;
            end
            MODE_RESET_CUR: begin
                c  = 8'd0;
                r  = 7'd0;
                wp = 1'b0;
            end
            default: ;
        endcase

        // nothing to draw: a lone cursor notice
        if (n == 3'd0) begin
            ops[0] = mk_op(OP_CURSOR, 7'd0, 7'd0, 8'd0, 8'd0, 21'd0, 16'd0, 1'b0);
            n      = 3'd1;
        end

        res.ops          = ops;
        res.last_idx     = 2'(n - 3'd1);
        res.cur_col      = c;
        res.cur_row      = r;
        res.wrap_pending = wp;
    end

endmodule

// ===== rtl/tgcw_out_buf.sv =====
module tgcw_out_buf (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  tgcw_pkg::step_t                 res,
    output logic                            load,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tgcw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast
);
    import tgcw_pkg::*;

    step_t      buf_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       at_last;
    logic       drain;
    gop_t       cur_op;

    assign at_last = (idx_reg == buf_reg.last_idx);
    assign drain   = valid_reg && m_tready;
    // a new item's results may enter once the last one held leaves
    assign load    = in_valid && (!valid_reg || (m_tready && at_last));

    // Control: valid flag and result index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (drain) begin
            if (at_last) begin
                valid_reg <= 1'b0;
                idx_reg   <= 2'd0;
            end else begin
                idx_reg   <= idx_reg + 2'd1;
            end
        end
    end

    // Payload: the whole list of results for one item
    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= res;
        end
    end

    assign cur_op   = buf_reg.ops[idx_reg];
    assign m_tvalid = valid_reg;
    assign m_tlast  = at_last;
    assign m_tuser  = cur_op.op;
    assign m_tdata  = {4'd0, buf_reg.wrap_pending, buf_reg.cur_row, buf_reg.cur_col,
                       cur_op.wide, cur_op.attribute, cur_op.glyph, cur_op.col_last,
                       cur_op.col_first, cur_op.row_last, cur_op.row_first};

endmodule
